// File: hdl/hcr_pkg.sv
// Types and constants shared by the Harris corner response block.
package hcr_pkg;

  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int PROD_W     = 21;
  localparam int SUM_W      = 25;
  localparam int TR_W       = 26;
  localparam int DET_W      = 50;
  localparam int DIVD_W     = 52;
  localparam int RESP_W     = 26;
  localparam int ROW_W      = 12;
  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_H_W-1:0] MAX_HEIGHT = 13'd4096;
  localparam logic [DIVD_W-1:0]  RESP_MAX   = 52'd33554431;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  typedef struct packed {
    logic [PROD_W-1:0]        xx;
    logic [PROD_W-1:0]        yy;
    logic signed [PROD_W-1:0] xy;
  } tensor_t;

endpackage

// File: hdl/hcr_if.sv
// Valid/ready stream interfaces for the pixel input and the response output.
interface hcr_pix_if import hcr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface hcr_resp_if import hcr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RESP_W-1:0] response;
  logic                     frame_last;
  modport source (output valid, output response, output frame_last, input ready);
  modport sink (input valid, input response, input frame_last, output ready);
endinterface

// File: hdl/hcr_div.sv
// Restoring divider, one quotient bit per cycle.
module hcr_div import hcr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [TR_W-1:0]   divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TR_W:0]     rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [TR_W:0]     shifted;
  logic              fits;

  assign shifted = {rem_q[TR_W-1:0], quo_q[DIVD_W-1]};
  assign fits    = shifted >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? shifted - {1'b0, divisor_i} : shifted;
      quo_q <= {quo_q[DIVD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: hdl/harris_corner_response_3x3_top.sv
// Top level of the 3x3 Harris corner response block.
//
// Pixels enter on the pix channel in raster order, one transaction each; the
// frame size comes from the image_width and image_height registers, which the
// user must write on the cfg port only while the block is idle; the block does
// not enforce this. A write restarts the frame. One response leaves on the
// resp channel for each interior position, that is (height-4) x (width-4) per
// frame, with frame_last on the final one. Each pixel is handled alone: a
// border pixel passes S_RD only, a tensor-only pixel also S_GRAD to S_TSH, and
// a responding one also S_SUM to S_OUT, with the 52-step restoring divider.
// Line data lives in two single-port memories, one entry per column, each
// holding the two previous rows.
// Reset clears the counters and windows, sets the frame to 640 x 480, and
// leaves the memories unwritten; no result depends on an entry that has not
// been written earlier in the frame.
// A result waits in the output register; if the receiver stalls, the next
// response waits in its final step and no new pixel is taken meanwhile.
module harris_corner_response_3x3_top import hcr_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  hcr_pix_if.sink               pix,
  hcr_resp_if.source            resp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_GRAD, S_PROD, S_TSH, S_SUM, S_MUL, S_DET, S_DIV, S_OUT
  } state_e;

  state_e              state_q;
  logic [CFG_W_W-1:0]  cfg_w_q;
  logic [CFG_H_W-1:0]  cfg_h_q;
  logic [AW-1:0]       col_q;
  logic [ROW_W-1:0]    row_q;
  logic [AW-1:0]       c_q;
  logic                inner_q, interior_q, last_q;
  logic [PIX_W-1:0]    p_q;
  logic [PIX_W-1:0]    win_q [9];
  tensor_t             twin_q [9];
  logic signed [GRAD_W-1:0] gx_q, gy_q;
  tensor_t             prod_q;
  logic [SUM_W-1:0]    sxx_q, syy_q;
  logic signed [TR_W-1:0] sxy_q;
  logic [DET_W-1:0]    a_q, b_q;
  logic [TR_W-1:0]     trace_q;
  logic [DIVD_W-1:0]   dvd_q;
  logic                div_start_q;
  logic                resp_valid_q;
  logic signed [RESP_W-1:0] resp_q;
  logic                resp_last_q;

  logic [2*PIX_W-1:0]  pix_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]  pix_rd_q;
  logic [$bits(tensor_t)*2-1:0] tens_mem [MAX_WIDTH];
  logic [$bits(tensor_t)*2-1:0] tens_rd_q;

  logic [WW-1:0]       w_eff;
  logic [CFG_H_W-1:0]  h_eff;
  logic [AW-1:0]       c_cur;
  logic [ROW_W-1:0]    r_cur;
  logic [AW-1:0]       tc;
  logic                accept;
  logic                div_done;
  logic [DIVD_W-1:0]   quo;

  always_comb begin
    if (cfg_w_q < CFG_W_W'(5)) w_eff = WW'(5);
    else if ({3'b0, cfg_w_q} > 14'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_w_q);
    if (cfg_h_q < CFG_H_W'(5)) h_eff = CFG_H_W'(5);
    else if (cfg_h_q > MAX_HEIGHT) h_eff = MAX_HEIGHT;
    else h_eff = cfg_h_q;
    c_cur = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
    r_cur = ({1'b0, row_q} >= h_eff) ? '0 : row_q;
  end

  assign tc        = c_q - AW'(2);
  assign accept    = pix.valid && pix.ready;
  assign pix.ready = (state_q == S_IDLE);

  // Each entry holds {row above the previous one, previous row} of a column.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) pix_rd_q <= pix_mem[c_cur];
    if (state_q == S_RD) pix_mem[c_q] <= {pix_rd_q[PIX_W-1:0], p_q};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) tens_rd_q <= tens_mem[tc];
    if (state_q == S_TSH) tens_mem[tc] <= {tens_rd_q[$bits(tensor_t)-1:0], prod_q};
  end

  hcr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (dvd_q),
    .divisor_i  (trace_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cfg_w_q      <= CFG_W_W'(640);
      cfg_h_q      <= CFG_H_W'(480);
      col_q        <= '0;
      row_q        <= '0;
      win_q        <= '{default: '0};
      twin_q       <= '{default: '0};
      div_start_q  <= 1'b0;
      resp_valid_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (resp.valid && resp.ready) resp_valid_q <= 1'b0;
      if (cfg_we_i && (cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT)) begin
        if (cfg_idx_i == CFG_WIDTH) cfg_w_q <= cfg_data_i[CFG_W_W-1:0];
        else cfg_h_q <= cfg_data_i;
        col_q <= '0;
        row_q <= '0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            p_q        <= pix.pixel;
            c_q        <= c_cur;
            inner_q    <= (r_cur >= ROW_W'(2)) && (c_cur >= AW'(2));
            interior_q <= (r_cur >= ROW_W'(4)) && (c_cur >= AW'(4));
            last_q     <= ({1'b0, r_cur} == h_eff - 1'b1) &&
                          ({1'b0, c_cur} == w_eff - 1'b1);
            if ({1'b0, c_cur} + 1'b1 >= w_eff) begin
              col_q <= '0;
              row_q <= ({1'b0, r_cur} + 1'b1 >= h_eff) ? '0 : r_cur + 1'b1;
            end else begin
              col_q <= c_cur + 1'b1;
              row_q <= r_cur;
            end
            state_q <= S_RD;
          end
        end
        S_RD: begin
          for (int k = 0; k < 3; k++) begin
            win_q[k*3]   <= win_q[k*3+1];
            win_q[k*3+1] <= win_q[k*3+2];
          end
          win_q[2] <= pix_rd_q[2*PIX_W-1:PIX_W];
          win_q[5] <= pix_rd_q[PIX_W-1:0];
          win_q[8] <= p_q;
          state_q  <= inner_q ? S_GRAD : S_IDLE;
        end
        S_GRAD: begin
          gx_q <= GRAD_W'(win_q[2]) - GRAD_W'(win_q[0])
                + (GRAD_W'(win_q[5]) << 1) - (GRAD_W'(win_q[3]) << 1)
                + GRAD_W'(win_q[8]) - GRAD_W'(win_q[6]);
          gy_q <= GRAD_W'(win_q[6]) - GRAD_W'(win_q[0])
                + (GRAD_W'(win_q[7]) << 1) - (GRAD_W'(win_q[1]) << 1)
                + GRAD_W'(win_q[8]) - GRAD_W'(win_q[2]);
          state_q <= S_PROD;
        end
        S_PROD: begin
          prod_q.xx <= PROD_W'(gx_q * gx_q);
          prod_q.yy <= PROD_W'(gy_q * gy_q);
          prod_q.xy <= PROD_W'(gx_q * gy_q);
          state_q   <= S_TSH;
        end
        S_TSH: begin
          for (int k = 0; k < 3; k++) begin
            twin_q[k*3]   <= twin_q[k*3+1];
            twin_q[k*3+1] <= twin_q[k*3+2];
          end
          twin_q[2] <= tens_rd_q[2*$bits(tensor_t)-1:$bits(tensor_t)];
          twin_q[5] <= tens_rd_q[$bits(tensor_t)-1:0];
          twin_q[8] <= prod_q;
          state_q   <= interior_q ? S_SUM : S_IDLE;
        end
        S_SUM: begin
          sxx_q <= SUM_W'(twin_q[0].xx) + (SUM_W'(twin_q[1].xx) << 1) + SUM_W'(twin_q[2].xx)
                 + (SUM_W'(twin_q[3].xx) << 1) + (SUM_W'(twin_q[4].xx) << 2)
                 + (SUM_W'(twin_q[5].xx) << 1) + SUM_W'(twin_q[6].xx)
                 + (SUM_W'(twin_q[7].xx) << 1) + SUM_W'(twin_q[8].xx);
          syy_q <= SUM_W'(twin_q[0].yy) + (SUM_W'(twin_q[1].yy) << 1) + SUM_W'(twin_q[2].yy)
                 + (SUM_W'(twin_q[3].yy) << 1) + (SUM_W'(twin_q[4].yy) << 2)
                 + (SUM_W'(twin_q[5].yy) << 1) + SUM_W'(twin_q[6].yy)
                 + (SUM_W'(twin_q[7].yy) << 1) + SUM_W'(twin_q[8].yy);
          sxy_q <= TR_W'(twin_q[0].xy) + (TR_W'(twin_q[1].xy) <<< 1) + TR_W'(twin_q[2].xy)
                 + (TR_W'(twin_q[3].xy) <<< 1) + (TR_W'(twin_q[4].xy) <<< 2)
                 + (TR_W'(twin_q[5].xy) <<< 1) + TR_W'(twin_q[6].xy)
                 + (TR_W'(twin_q[7].xy) <<< 1) + TR_W'(twin_q[8].xy);
          state_q <= S_MUL;
        end
        S_MUL: begin
          a_q     <= DET_W'(sxx_q) * DET_W'(syy_q);
          b_q     <= sxy_q[TR_W-1] ? DET_W'(SUM_W'(-sxy_q)) * DET_W'(SUM_W'(-sxy_q))
                                   : DET_W'(SUM_W'(sxy_q)) * DET_W'(SUM_W'(sxy_q));
          trace_q <= TR_W'(sxx_q) + TR_W'(syy_q);
          state_q <= S_DET;
        end
        S_DET: begin
          dvd_q       <= (a_q > b_q) ? {a_q - b_q, 2'b00} : '0;
          div_start_q <= 1'b1;
          state_q     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state_q <= S_OUT;
        end
        S_OUT: begin
          if (!resp_valid_q) begin
            resp_valid_q <= 1'b1;
            resp_last_q  <= last_q;
            // A zero trace gives a zero response.
            if (trace_q == '0) resp_q <= '0;
            else if (quo > RESP_MAX) resp_q <= RESP_W'(RESP_MAX);
            else resp_q <= RESP_W'(quo);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign resp.valid      = resp_valid_q;
  assign resp.response   = resp_q;
  assign resp.frame_last = resp_last_q;

endmodule
